[rtl/core/lmfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_pkg
// shared constants, codes and controller/datapath interface types for the
// led matrix frame serializer
// ----------------------------------------------------------------------------
package lmfs_pkg;

  localparam int MAX_MODULES          = 8;
  localparam int BYTES_PER_MODULE_MAX = 48;
  localparam int STORE_SIZE           = MAX_MODULES * BYTES_PER_MODULE_MAX;
  localparam int ADDR_W               = $clog2(STORE_SIZE);
  // wide enough for 48 bytes times the largest module count
  localparam int SPAN_W               = $clog2(48 * MAX_MODULES + 1);
  localparam int CNT_W                = $clog2(MAX_MODULES + 1);
  localparam int IDX_W                = 2;

  localparam logic [7:0] HEADER_BYTE = 8'd160;

  localparam logic [2:0] OP_PLOT  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_TEST  = 3'd3;
  localparam logic [2:0] OP_EMIT  = 3'd4;

  localparam logic [IDX_W-1:0] CFG_MODULE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] CFG_GEOMETRY     = 2'd1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PLOT_RD,
    ST_PLOT_WR,
    ST_BULK,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic walk_init;
    logic walk_bulk;
    logic plot_rd;
    logic plot_wr;
    logic emit_rd;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       plot_ok;
    logic       bulk_ok;
    logic       emit_ok;
    logic       walk_done;
    logic       init_done;
    logic       out_free;
    logic       emit_last;
  } dp_status_t;

endpackage

[rtl/core/lmfs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_ctrl
// sequencer for the frame serializer: power-up clear, request dispatch,
// pixel read-modify-write, bulk walk and packet emit
// ----------------------------------------------------------------------------
module lmfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lmfs_pkg::dp_status_t status_i,
  output lmfs_pkg::ctrl_cmd_t  cmd_o
);

  lmfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmfs_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lmfs_pkg::ST_INIT: begin
        cmd_o.walk_init = 1'b1;
        if (status_i.init_done) begin
          state_d = lmfs_pkg::ST_IDLE;
        end
      end
      lmfs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = lmfs_pkg::ST_DISPATCH;
        end
      end
      lmfs_pkg::ST_DISPATCH: begin
        state_d = lmfs_pkg::ST_IDLE;
        case (status_i.op)
          lmfs_pkg::OP_PLOT: begin
            if (status_i.plot_ok) state_d = lmfs_pkg::ST_PLOT_RD;
          end
          lmfs_pkg::OP_CLEAR, lmfs_pkg::OP_FILL, lmfs_pkg::OP_TEST: begin
            if (status_i.bulk_ok) state_d = lmfs_pkg::ST_BULK;
          end
          lmfs_pkg::OP_EMIT: begin
            if (status_i.emit_ok) state_d = lmfs_pkg::ST_EMIT_RD;
          end
          default: begin
            state_d = lmfs_pkg::ST_IDLE;
          end
        endcase
      end
      lmfs_pkg::ST_PLOT_RD: begin
        cmd_o.plot_rd = 1'b1;
        state_d       = lmfs_pkg::ST_PLOT_WR;
      end
      lmfs_pkg::ST_PLOT_WR: begin
        cmd_o.plot_wr = 1'b1;
        state_d       = lmfs_pkg::ST_IDLE;
      end
      lmfs_pkg::ST_BULK: begin
        cmd_o.walk_bulk = 1'b1;
        if (status_i.walk_done) begin
          state_d = lmfs_pkg::ST_IDLE;
        end
      end
      lmfs_pkg::ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = lmfs_pkg::ST_EMIT_OUT;
      end
      lmfs_pkg::ST_EMIT_OUT: begin
        // hold here until the output register can take the byte
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = status_i.emit_last ? lmfs_pkg::ST_IDLE : lmfs_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = lmfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/lmfs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_dp
// datapath: configuration registers, request latch, frame store memory,
// walk and emit counters, packet byte formatter and output register
// ----------------------------------------------------------------------------
module lmfs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [lmfs_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [3:0]                       cfg_data_i,
  input  logic [2:0]                       operation_i,
  input  logic [7:0]                       x_pos_i,
  input  logic [3:0]                       y_pos_i,
  input  logic                             pixel_value_i,
  input  logic [2:0]                       module_index_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [7:0]                       out_byte_o,
  output logic [2:0]                       out_module_o,
  output logic                             last_byte_o,
  input  lmfs_pkg::ctrl_cmd_t              cmd_i,
  output lmfs_pkg::dp_status_t             status_o
);

  localparam int SW = lmfs_pkg::SPAN_W;
  localparam int CW = lmfs_pkg::CNT_W;

  // configuration
  logic [3:0] count_q;
  logic       geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd1;
      geo_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lmfs_pkg::CFG_MODULE_COUNT) count_q <= cfg_data_i;
      if (cfg_index_i == lmfs_pkg::CFG_GEOMETRY)     geo_q   <= cfg_data_i[0];
    end
  end

  // request latch
  logic [2:0] op_q;
  logic [7:0] x_q;
  logic [3:0] y_q;
  logic       val_q;
  logic [2:0] mi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= operation_i;
      x_q   <= x_pos_i;
      y_q   <= y_pos_i;
      val_q <= pixel_value_i;
      mi_q  <= module_index_i;
    end
  end

  // geometry arithmetic
  logic [CW-1:0] cnt;
  logic [SW-1:0] cnt32, cnt16, cnt8, total, base, mi32, mi16, plot_lim, plot_addr;
  logic [5:0]    t_bytes;
  logic          plot_in;

  always_comb begin
    if (32'(count_q) > lmfs_pkg::MAX_MODULES) cnt = CW'(lmfs_pkg::MAX_MODULES);
    else                                      cnt = CW'(count_q);
    cnt32   = SW'(cnt) << 5;
    cnt16   = SW'(cnt) << 4;
    cnt8    = SW'(cnt) << 3;
    mi32    = SW'(mi_q) << 5;
    mi16    = SW'(mi_q) << 4;
    t_bytes = geo_q ? 6'd32 : 6'd48;
    total   = geo_q ? cnt32 : cnt32 + cnt16;
    base    = geo_q ? mi32 : mi32 + mi16;
    if (geo_q) begin
      plot_lim  = cnt32;
      plot_in   = (y_q[3] == 1'b0);
      plot_addr = SW'(x_q);
    end else begin
      plot_lim  = cnt16 + cnt8;
      plot_in   = 1'b1;
      plot_addr = (SW'(x_q) << 1) + SW'(y_q[3]);
    end
  end

  // frame store
  logic [7:0]                  mem [lmfs_pkg::STORE_SIZE];
  logic [7:0]                  mem_rdata_q;
  logic                        rd_oob_q;
  logic [7:0]                  cur;
  logic                        we, re;
  logic [SW-1:0]               waddr, raddr;
  logic [7:0]                  wdata, mask;
  logic [SW-1:0]               walk_q;
  logic [5:0]                  k_q;
  logic [SW-1:0]               emit_addr;
  logic                        k_reads;

  assign mask      = 8'h80 >> y_q[2:0];
  assign emit_addr = base + SW'(k_q) - SW'(1);
  assign k_reads   = (k_q != 6'd0) && (k_q <= t_bytes);
  assign cur       = rd_oob_q ? 8'h00 : mem_rdata_q;

  always_comb begin
    we    = 1'b0;
    waddr = walk_q;
    wdata = 8'h00;
    if (cmd_i.walk_init) begin
      we = 1'b1;
    end else if (cmd_i.walk_bulk) begin
      we = (32'(walk_q) < lmfs_pkg::STORE_SIZE);
      case (op_q)
        lmfs_pkg::OP_FILL: wdata = 8'hff;
        lmfs_pkg::OP_TEST: wdata = walk_q[7:0];
        default:           wdata = 8'h00;
      endcase
    end else if (cmd_i.plot_wr) begin
      we    = 1'b1;
      waddr = plot_addr;
      wdata = val_q ? (cur | mask) : (cur & ~mask);
    end
  end

  assign raddr = cmd_i.plot_rd ? plot_addr : emit_addr;
  assign re    = cmd_i.plot_rd || (cmd_i.emit_rd && k_reads);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr[lmfs_pkg::ADDR_W-1:0]] <= wdata;
    if (re && (32'(raddr) < lmfs_pkg::STORE_SIZE)) begin
      mem_rdata_q <= mem[raddr[lmfs_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_oob_q <= 1'b0;
    end else if (re) begin
      rd_oob_q <= !(32'(raddr) < lmfs_pkg::STORE_SIZE);
    end
  end

  // walk counter shared by the power-up clear and bulk requests
  logic walk_done, init_done;
  assign walk_done = (walk_q == total - SW'(1));
  assign init_done = (walk_q == SW'(lmfs_pkg::STORE_SIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.walk_init) begin
      walk_q <= init_done ? '0 : walk_q + SW'(1);
    end else if (cmd_i.walk_bulk) begin
      walk_q <= walk_done ? '0 : walk_q + SW'(1);
    end
  end

  // packet formatter
  logic [7:0] prev_q, f0_q, f1_q, emit_byte;
  logic       emit_last;

  assign emit_last = (k_q == t_bytes + 6'd2);

  always_comb begin
    if (k_q == 6'd0)                emit_byte = lmfs_pkg::HEADER_BYTE;
    else if (k_q == 6'd1)           emit_byte = {2'b00, cur[7:2]};
    else if (k_q <= t_bytes)        emit_byte = {prev_q[1:0], cur[7:2]};
    else if (k_q == t_bytes + 6'd1) emit_byte = {prev_q[1:0], f0_q[7:2]};
    else                            emit_byte = {f0_q[1:0], f1_q[7:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.latch_in) begin
      k_q <= '0;
    end else if (cmd_i.emit_load) begin
      k_q <= k_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load && k_reads) begin
      prev_q <= cur;
      if (k_q == 6'd1) f0_q <= cur;
      if (k_q == 6'd2) f1_q <= cur;
    end
  end

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [2:0] out_module_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_byte_q   <= emit_byte;
      out_module_q <= mi_q;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_module_o = out_module_q;
  assign last_byte_o  = out_last_q;

  always_comb begin
    status_o           = '0;
    status_o.op        = op_q;
    status_o.plot_ok   = plot_in && (SW'(x_q) < plot_lim)
                         && (32'(plot_addr) < lmfs_pkg::STORE_SIZE);
    status_o.bulk_ok   = (total != '0);
    status_o.emit_ok   = (32'(mi_q) < 32'(cnt));
    status_o.walk_done = walk_done;
    status_o.init_done = init_done;
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.emit_last = emit_last;
  end

endmodule

[rtl/core/led_matrix_frame_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_serializer
// column-byte frame store for a chain of led matrix modules, with pixel,
// bulk and packet emit requests
// ----------------------------------------------------------------------------
// after reset the frame store is cleared by a pass over every location; no request
// is taken until it ends, configuration writes are taken at any time
// plot: dispatch, store read, then store write before the next request is taken
// (single-port read-modify-write); clear, fill, test pattern: T*count store bytes, one store write per cycle
// emit: dispatch, then for each byte a memory read and a format into the output
// register, held while the output is stalled; T+3 bytes per packet
module led_matrix_frame_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 operation_i,
  input  logic [7:0]                 x_pos_i,
  input  logic [3:0]                 y_pos_i,
  input  logic                       pixel_value_i,
  input  logic [2:0]                 module_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [2:0]                 out_module_o,
  output logic                       last_byte_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lmfs_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [3:0]                 cfg_data_i
);

  lmfs_pkg::ctrl_cmd_t  cmd;
  lmfs_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lmfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lmfs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .pixel_value_i  (pixel_value_i),
    .module_index_i (module_index_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .out_module_o   (out_module_o),
    .last_byte_o    (last_byte_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

[rtl/core/lmfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_checker
// port-level checks on the frame serializer: output hold, packet framing
// and request sequencing
// ----------------------------------------------------------------------------
module lmfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [2:0] out_module_o,
  input logic       last_byte_o
);

  logic       out_acc;
  logic [5:0] nbytes_q;

  assign out_acc = out_valid_o && out_ready_i;

  // bytes taken since the previous end of packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbytes_q <= '0;
    end else if (out_acc) begin
      nbytes_q <= last_byte_o ? 6'd0 : nbytes_q + 6'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_module_o) && $stable(last_byte_o))
    else $error("output changed while stalled");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (nbytes_q == 6'd0) |-> out_byte_o == lmfs_pkg::HEADER_BYTE)
    else $error("packet does not open with the header byte");

  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_byte_o |-> (nbytes_q == 6'd34) || (nbytes_q == 6'd50))
    else $error("packet length is not 35 or 51 bytes");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one is dispatched");

endmodule

bind led_matrix_frame_serializer lmfs_checker u_lmfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .out_module_o (out_module_o),
  .last_byte_o  (last_byte_o)
);
